/* sv/pahs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Pressure altitude smoother package
// Widths, register indexes, reset values, state type and helper functions
// shared by the smoother unit and its checker.
// ----------------------------------------------------------------------------
package pahs_pkg;

   // Field widths.
   localparam int SAMPLE_W = 24;           // raw pressure sample
   localparam int SCALE_W  = 24;           // altitude scale, unsigned Q8.16
   localparam int GAIN_W   = 17;           // gains, unsigned Q1.16
   localparam int Q_W      = 32;           // Q16.16 level and trend

   // Serial multiplier geometry.
   localparam int MCAND_W  = 34;           // signed multiplicand
   localparam int ACC_HI_W = MCAND_W + 1;  // upper accumulator half
   localparam int ACC_LO_W = SCALE_W;      // product bits shifted out
   localparam int PROD_W   = ACC_HI_W + ACC_LO_W;
   localparam int SUM_W    = 37;           // rounded product plus offset
   localparam int CNT_W    = 5;

   localparam logic [CNT_W-1:0] CNT_SCALE = CNT_W'(SCALE_W - 1);
   localparam logic [CNT_W-1:0] CNT_GAIN  = CNT_W'(GAIN_W - 1);

   // Configuration port.
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_GROUND_PRESSURE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALTITUDE_SCALE  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_GAIN      = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TREND_GAIN      = 8'd3;

   localparam logic [SAMPLE_W-1:0] RST_GROUND_PRESSURE = 24'd0;
   localparam logic [SCALE_W-1:0]  RST_ALTITUDE_SCALE  = 24'd87256;
   localparam logic [GAIN_W-1:0]   RST_LEVEL_GAIN      = 17'd1966;
   localparam logic [GAIN_W-1:0]   RST_TREND_GAIN      = 17'd655;

   localparam logic [GAIN_W-1:0]   GAIN_ONE = 17'd65536;

   localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_ALT,
      ST_FIN_ALT,
      ST_MUL_LVL,
      ST_FIN_LVL,
      ST_LOAD_TRD,
      ST_MUL_TRD,
      ST_FIN_TRD
   } state_type;

   // Gains above one are treated as exactly one.
   function automatic logic [GAIN_W-1:0] gain_clamp(input logic [GAIN_W-1:0] g);
      logic [GAIN_W-1:0] r;
      r = g[GAIN_W-1] ? GAIN_ONE : g;
      return r;
   endfunction

   // Saturate a wide signed value to signed 32 bits.
   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] x);
      logic [PROD_W-Q_W:0]  top;
      logic signed [Q_W-1:0] r;
      top = x[PROD_W-1:Q_W-1];
      if ((&top) || !(|top)) begin
         r = x[Q_W-1:0];
      end else if (x[PROD_W-1]) begin
         r = Q_MIN;
      end else begin
         r = Q_MAX;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* sv/pressure_altitude_holt_smoother_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Pressure altitude Holt smoother unit
// Converts raw pressure samples to Q16.16 altitude and smooths them with
// Holt double exponential smoothing, one sample per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one raw pressure sample per transaction. The
//   rsp_ channel returns one transaction per sample holding the new smoothed
//   altitude and the new trend, both saturated Q16.16. The csr_ channel
//   writes ground pressure, altitude scale and the two gains; it is always
//   ready and is meant to be written while no sample is in flight.
// Sequencing:
//   All three products go through one shift-and-add multiplier that retires
//   one multiplier bit per cycle: one pass over the altitude scale and one
//   over each gain, with the finishing steps FIN_ALT, FIN_LVL, LOAD_TRD
//   and FIN_TRD. req_tready is high only while the unit is idle, so a new
//   sample is taken only once the previous one has left its final step.
// Stalls:
//   The result sits in an output register, so the next sample is accepted
//   while the previous result still waits. If the next result is ready
//   before the old one is taken, the unit holds it in its final step.
// Reset:
//   Synchronous reset clears the level and trend estimates, drops
//   rsp_tvalid and restores the default register values.
// ----------------------------------------------------------------------------
module pressure_altitude_holt_smoother_unit
   import pahs_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,

   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire  [SAMPLE_W-1:0]    req_tdata,    // [23:0] pressure_sample

   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [2*Q_W-1:0]       rsp_tdata,    // [31:0] smoothed_altitude,
                                                // [63:32] altitude_trend

   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire  [CSR_IDX_W-1:0]   csr_index,
   input  wire  [CSR_DATA_W-1:0]  csr_data
);

   state_type state_ff, state_in;

   // Configuration registers.
   logic [SAMPLE_W-1:0] ground_ff, ground_in;
   logic [SCALE_W-1:0]  scale_ff,  scale_in;
   logic [GAIN_W-1:0]   lgain_ff,  lgain_in;
   logic [GAIN_W-1:0]   tgain_ff,  tgain_in;

   // Smoother state.
   logic signed [Q_W-1:0] level_ff, level_in;
   logic signed [Q_W-1:0] trend_ff, trend_in;
   logic signed [Q_W:0]   sum_ff,   sum_in;      // level + trend
   logic signed [Q_W-1:0] lvl_new_ff, lvl_new_in;

   // Serial multiplier: the multiplier operand shifts out LSB first while
   // low product bits shift into the lower accumulator half.
   logic signed [MCAND_W-1:0]  mcand_ff,  mcand_in;
   logic [SCALE_W-1:0]         mplier_ff, mplier_in;
   logic [CNT_W-1:0]           cnt_ff,    cnt_in;
   logic signed [ACC_HI_W-1:0] phi_ff,    phi_in;
   logic [ACC_LO_W-1:0]        plo_ff,    plo_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2*Q_W-1:0]   rsp_data_ff,  rsp_data_in;

   logic                       mul_done;
   logic                       out_free;
   logic signed [ACC_HI_W-1:0] step_sum;
   logic signed [SAMPLE_W:0]   press_diff;
   logic signed [Q_W-1:0]      alt_sat;
   logic signed [ACC_HI_W:0]   rnd_q;
   logic signed [SUM_W-1:0]    lvl_sum;
   logic signed [SUM_W-1:0]    trd_sum;
   logic signed [Q_W-1:0]      lvl_sat;
   logic signed [Q_W-1:0]      trd_sat;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign mul_done = (cnt_ff == '0);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // One multiplier bit per cycle: add the multiplicand when the bit is set.
   assign step_sum = phi_ff + (mplier_ff[0] ? {mcand_ff[MCAND_W-1], mcand_ff}
                                            : {ACC_HI_W{1'b0}});

   assign press_diff = $signed({1'b0, ground_ff}) - $signed({1'b0, req_tdata});

   // The altitude uses the full product without rounding.
   assign alt_sat = sat_q($signed({phi_ff, plo_ff}));

   // After a gain pass the product's bit 16 sits at the top of the lower
   // half and bit 15 just below it. Rounding half up is the product shifted
   // down by 16 plus bit 15.
   assign rnd_q = $signed({phi_ff, plo_ff[ACC_LO_W-1]})
                + $signed({{ACC_HI_W{1'b0}}, plo_ff[ACC_LO_W-2]});

   // The Q1.16 blend is rewritten as offset*1.0 + gain*(target - offset),
   // so each estimate needs a single product.
   assign lvl_sum = {rnd_q[ACC_HI_W], rnd_q}
                  + {{(SUM_W-Q_W-1){sum_ff[Q_W]}}, sum_ff};
   assign trd_sum = {rnd_q[ACC_HI_W], rnd_q}
                  + {{(SUM_W-Q_W){trend_ff[Q_W-1]}}, trend_ff};

   assign lvl_sat = sat_q({{(PROD_W-SUM_W){lvl_sum[SUM_W-1]}}, lvl_sum});
   assign trd_sat = sat_q({{(PROD_W-SUM_W){trd_sum[SUM_W-1]}}, trd_sum});

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_tvalid) state_in = ST_MUL_ALT;
         ST_MUL_ALT:  if (mul_done)   state_in = ST_FIN_ALT;
         ST_FIN_ALT:  state_in = ST_MUL_LVL;
         ST_MUL_LVL:  if (mul_done)   state_in = ST_FIN_LVL;
         ST_FIN_LVL:  state_in = ST_LOAD_TRD;
         ST_LOAD_TRD: state_in = ST_MUL_TRD;
         ST_MUL_TRD:  if (mul_done)   state_in = ST_FIN_TRD;
         ST_FIN_TRD:  if (out_free)   state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath and output updates.
   always_comb begin
      ground_in    = ground_ff;
      scale_in     = scale_ff;
      lgain_in     = lgain_ff;
      tgain_in     = tgain_ff;
      level_in     = level_ff;
      trend_in     = trend_ff;
      sum_in       = sum_ff;
      lvl_new_in   = lvl_new_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      cnt_in       = cnt_ff;
      phi_in       = phi_ff;
      plo_in       = plo_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_GROUND_PRESSURE: ground_in = csr_data[SAMPLE_W-1:0];
            CSR_ALTITUDE_SCALE:  scale_in  = csr_data[SCALE_W-1:0];
            CSR_LEVEL_GAIN:      lgain_in  = csr_data[GAIN_W-1:0];
            CSR_TREND_GAIN:      tgain_in  = csr_data[GAIN_W-1:0];
            default:             ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mcand_in  = {{(MCAND_W-SAMPLE_W-1){press_diff[SAMPLE_W]}}, press_diff};
               mplier_in = scale_ff;
               cnt_in    = CNT_SCALE;
               phi_in    = '0;
               plo_in    = '0;
               sum_in    = {level_ff[Q_W-1], level_ff} + {trend_ff[Q_W-1], trend_ff};
            end
         end
         ST_MUL_ALT, ST_MUL_LVL, ST_MUL_TRD: begin
            phi_in    = {step_sum[ACC_HI_W-1], step_sum[ACC_HI_W-1:1]};
            plo_in    = {step_sum[0], plo_ff[ACC_LO_W-1:1]};
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - 1'b1;
         end
         ST_FIN_ALT: begin
            mcand_in  = {{(MCAND_W-Q_W){alt_sat[Q_W-1]}}, alt_sat}
                      - {{(MCAND_W-Q_W-1){sum_ff[Q_W]}}, sum_ff};
            mplier_in = {{(SCALE_W-GAIN_W){1'b0}}, gain_clamp(lgain_ff)};
            cnt_in    = CNT_GAIN;
            phi_in    = '0;
            plo_in    = '0;
         end
         ST_FIN_LVL: begin
            lvl_new_in = lvl_sat;
         end
         ST_LOAD_TRD: begin
            // New level minus old level minus old trend.
            mcand_in  = {{(MCAND_W-Q_W){lvl_new_ff[Q_W-1]}}, lvl_new_ff}
                      - {{(MCAND_W-Q_W-1){sum_ff[Q_W]}}, sum_ff};
            mplier_in = {{(SCALE_W-GAIN_W){1'b0}}, gain_clamp(tgain_ff)};
            cnt_in    = CNT_GAIN;
            phi_in    = '0;
            plo_in    = '0;
         end
         ST_FIN_TRD: begin
            if (out_free) begin
               level_in     = lvl_new_ff;
               trend_in     = trd_sat;
               rsp_data_in  = {trd_sat, lvl_new_ff};
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ground_ff    <= RST_GROUND_PRESSURE;
         scale_ff     <= RST_ALTITUDE_SCALE;
         lgain_ff     <= RST_LEVEL_GAIN;
         tgain_ff     <= RST_TREND_GAIN;
         level_ff     <= '0;
         trend_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ground_ff    <= ground_in;
         scale_ff     <= scale_in;
         lgain_ff     <= lgain_in;
         tgain_ff     <= tgain_in;
         level_ff     <= level_in;
         trend_ff     <= trend_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      lvl_new_ff  <= lvl_new_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      cnt_ff      <= cnt_in;
      phi_ff      <= phi_in;
      plo_ff      <= plo_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

/* sv/pahs_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Pressure altitude smoother checker
// Port-level assertions on the smoother unit, attached by a bind statement.
// ----------------------------------------------------------------------------
module pahs_checker
   import pahs_pkg::*;
(
   input wire                   clock,
   input wire                   reset,
   input wire                   req_tvalid,
   input wire                   req_tready,
   input wire                   rsp_tvalid,
   input wire                   rsp_tready,
   input wire [2*Q_W-1:0]       rsp_tdata
);

   // A stalled result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // After taking a sample the unit drops req_tready and keeps it low while busy.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready)
      else $error("sample accepted while busy");

   // A new result never appears right after a sample was taken.
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("result appeared too early");

   // Reset empties the output.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind pressure_altitude_holt_smoother_unit pahs_checker u_pahs_checker (.*);
`default_nettype wire
